// ===== hdl/swk_pkg.sv =====
// ----------------------------------------------------------------------------
// Swerve wheel kinematics package
// Shared constants, lookup tables and helper types for the swerve wheel
// kinematics unit.
// ----------------------------------------------------------------------------
package swk_pkg;

	// Default number of CORDIC micro-rotations (valid range 8 to 24).
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int CORDIC_STAGES_MAX = 24;

	// Datapath widths.
	localparam int ROT_W = 27;   // rotation CORDIC and wheel sums
	localparam int VEC_W = 29;   // vectoring CORDIC
	localparam int MAG_W = 21;   // gain corrected magnitude

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] REG_CHASSIS_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHASSIS_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_DEADBAND     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_DEADBAND     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_DEADBAND  = 3'd4;

	localparam logic [11:0] CHASSIS_RESET = 12'd500;
	// floor(sqrt(2^30 * 500^2 / (500^2 + 500^2)))
	localparam logic [15:0] COEF_RESET    = 16'd23170;

	// Full speed scale (1.0).
	localparam logic [15:0] SCALE_ONE = 16'd32768;

	// CORDIC gain correction, 1/K in Q30.
	localparam logic [29:0] GAIN_Q30 = 30'd652032874;

	// atan(2^-i) in units of 2^-32 of a full circle.
	localparam logic [31:0] ATAN_TAB [CORDIC_STAGES_MAX] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// Coefficient sequencer states.
	typedef enum logic [3:0] {
		CF_IDLE = 4'b0001,
		CF_LOAD = 4'b0010,
		CF_DIV  = 4'b0100,
		CF_SQRT = 4'b1000
	} coef_state_t;

	// Side information that rides along the rotation stages.
	typedef struct packed {
		logic                    teleop;
		logic [15:0]             scale;
		logic signed [ROT_W-1:0] turn_l;
		logic signed [ROT_W-1:0] turn_w;
	} rot_side_t;

	// Side information that rides along the vectoring stages.
	typedef struct packed {
		logic        teleop;
		logic [15:0] scale;
		logic [3:0]  zero;
	} vec_side_t;

	// Zero a value whose magnitude lies below the deadband.
	function automatic logic signed [16:0] apply_deadband(
		input logic signed [16:0] v,
		input logic [14:0]        db
	);
		logic [16:0] mag;
		mag = v[16] ? 17'(-v) : 17'(v);
		return (mag < {2'b00, db}) ? 17'sd0 : v;
	endfunction

endpackage

// ===== hdl/swerve_wheel_kinematics_unit.sv =====
// ----------------------------------------------------------------------------
// Swerve wheel kinematics unit
// Inverse kinematics for a four wheel swerve chassis: one drive command in,
// the speed and steering angle of all four wheels out.
// ----------------------------------------------------------------------------
// Usage:
// A command beat enters on the s_ channel and its wheel targets leave on the
// m_ channel, one result beat per command, in order. s_tdata carries the
// commands, s_tuser selects teleop (0) or autonomous (1) handling.
// Chassis geometry and deadbands are set through the cfg channel while no
// command is in flight.
// The pipeline holds both CORDIC chains, one micro-rotation per stage;
// one command can enter every clock cycle while neither the coefficient
// sequencer nor a full skid register holds s_tready low.
// Writing the chassis length or width starts a sequencer that derives the
// L/r and W/r coefficients with a bit-serial divider and square root; it
// keeps s_tready and cfg_ready low until both coefficients are in place.
// Reset clears the pipeline, loads the default geometry (500 by 500, with
// its coefficients already in place) and zero deadbands.
// When the receiver stalls, the result waiting on m_ moves into a skid
// register and is held there while the pipeline advances once more; the
// pipeline then stops and s_tready drops until the skid register empties.
// Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module swerve_wheel_kinematics_unit #(
	parameter int CORDIC_STAGES = swk_pkg::CORDIC_STAGES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Command stream.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [15:0] strafe_cmd, [31:16] forward_cmd, [47:32] turn_cmd,
	// [63:48] heading, [79:64] speed_scale, [80] facing_back, rest zero
	input  logic [87:0]                     s_tdata,
	// [0] req_type
	input  logic                            s_tuser,
	// Wheel target stream.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [15:0] front_left_speed, [31:16] front_right_speed,
	// [47:32] rear_left_speed, [63:48] rear_right_speed,
	// [79:64] front_left_angle, [95:80] front_right_angle,
	// [111:96] rear_left_angle, [127:112] rear_right_angle
	output logic [127:0]                    m_tdata,
	// Configuration writes.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [swk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swk_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int N     = CORDIC_STAGES;
	localparam int NST   = 2 * N + 7;
	localparam int RW    = swk_pkg::ROT_W;
	localparam int VW    = swk_pkg::VEC_W;
	localparam int MW    = swk_pkg::MAG_W;

	// ------------------------------------------------------------------
	// Configuration registers and coefficient sequencer
	// ------------------------------------------------------------------
	logic [11:0] len_q, wid_q;
	logic [14:0] xdb_q, ydb_q, tdb_q;
	logic [15:0] kl_q, kw_q;

	swk_pkg::coef_state_t cf_state_q;
	logic        sel_q;
	logic [4:0]  cnt_q;
	logic [23:0] l2_q, w2_q;
	logic [24:0] sum_q;
	logic [25:0] rem_q;
	logic [30:0] quo_q;
	logic [31:0] sqv_q;
	logic [17:0] sqrem_q;
	logic [15:0] root_q;

	logic        cfg_acc;
	logic        busy;
	logic [23:0] l2_c, w2_c;
	logic [24:0] sum_c;
	logic [25:0] div_trial, div_rem;
	logic        div_ge;
	logic [18:0] sq_cur, sq_trial;
	logic        sq_ge;
	logic [15:0] root_c;

	assign busy      = (cf_state_q != swk_pkg::CF_IDLE);
	assign cfg_ready = !busy;
	assign cfg_acc   = cfg_valid && cfg_ready;

	always_comb begin
		l2_c      = 24'(len_q * len_q);
		w2_c      = 24'(wid_q * wid_q);
		sum_c     = {1'b0, l2_c} + {1'b0, w2_c};
		// One restoring division step per cycle; the first step uses the
		// dividend without a shift.
		div_trial = (cnt_q == 5'd0) ? {2'b00, (sel_q ? w2_q : l2_q)}
		                            : {rem_q[24:0], 1'b0};
		div_ge    = (div_trial >= {1'b0, sum_q});
		div_rem   = div_ge ? (div_trial - {1'b0, sum_q}) : div_trial;
		// One digit-by-digit square root step per cycle.
		sq_cur    = {sqrem_q[16:0], sqv_q[31:30]};
		sq_trial  = {1'b0, root_q, 2'b01};
		sq_ge     = (sq_cur >= sq_trial);
		root_c    = {root_q[14:0], sq_ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= swk_pkg::CHASSIS_RESET;
			wid_q      <= swk_pkg::CHASSIS_RESET;
			xdb_q      <= '0;
			ydb_q      <= '0;
			tdb_q      <= '0;
			kl_q       <= swk_pkg::COEF_RESET;
			kw_q       <= swk_pkg::COEF_RESET;
			cf_state_q <= swk_pkg::CF_IDLE;
			sel_q      <= 1'b0;
			cnt_q      <= '0;
		end else begin
			if (cfg_acc) begin
				case (cfg_index)
					swk_pkg::REG_CHASSIS_LENGTH: len_q <= cfg_data[11:0];
					swk_pkg::REG_CHASSIS_WIDTH:  wid_q <= cfg_data[11:0];
					swk_pkg::REG_X_DEADBAND:     xdb_q <= cfg_data;
					swk_pkg::REG_Y_DEADBAND:     ydb_q <= cfg_data;
					swk_pkg::REG_TURN_DEADBAND:  tdb_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (cf_state_q)
				swk_pkg::CF_IDLE: begin
					if (cfg_acc && (cfg_index == swk_pkg::REG_CHASSIS_LENGTH ||
					                cfg_index == swk_pkg::REG_CHASSIS_WIDTH)) begin
						cf_state_q <= swk_pkg::CF_LOAD;
					end
				end
				swk_pkg::CF_LOAD: begin
					sel_q <= 1'b0;
					cnt_q <= '0;
					if (sum_c == '0) begin
						// Degenerate chassis: both coefficients are zero.
						kl_q       <= '0;
						kw_q       <= '0;
						cf_state_q <= swk_pkg::CF_IDLE;
					end else begin
						cf_state_q <= swk_pkg::CF_DIV;
					end
				end
				swk_pkg::CF_DIV: begin
					if (cnt_q == 5'd30) begin
						cnt_q      <= '0;
						cf_state_q <= swk_pkg::CF_SQRT;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				swk_pkg::CF_SQRT: begin
					if (cnt_q == 5'd15) begin
						cnt_q <= '0;
						if (!sel_q) begin
							kl_q       <= root_c;
							sel_q      <= 1'b1;
							cf_state_q <= swk_pkg::CF_DIV;
						end else begin
							kw_q       <= root_c;
							cf_state_q <= swk_pkg::CF_IDLE;
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				default: cf_state_q <= swk_pkg::CF_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cf_state_q)
			swk_pkg::CF_LOAD: begin
				l2_q  <= l2_c;
				w2_q  <= w2_c;
				sum_q <= sum_c;
			end
			swk_pkg::CF_DIV: begin
				rem_q <= div_rem;
				quo_q <= {quo_q[29:0], div_ge};
				if (cnt_q == 5'd30) begin
					sqv_q   <= {1'b0, quo_q[29:0], div_ge};
					sqrem_q <= '0;
					root_q  <= '0;
				end
			end
			swk_pkg::CF_SQRT: begin
				sqrem_q <= sq_ge ? 18'(sq_cur - sq_trial) : 18'(sq_cur);
				root_q  <= root_c;
				sqv_q   <= {sqv_q[29:0], 2'b00};
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline control: all stages move together while the skid register
	// is empty.
	// ------------------------------------------------------------------
	logic           adv;
	logic           in_acc;
	logic [NST-1:0] pipe_vld_q;
	logic           skid_vld_q;
	logic [127:0]   skid_data_q;
	logic [127:0]   res_data;

	assign adv      = !skid_vld_q;
	assign s_tready = adv && !busy;
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_vld_q <= '0;
			skid_vld_q <= 1'b0;
		end else begin
			if (adv) begin
				pipe_vld_q <= {pipe_vld_q[NST-2:0], in_acc};
				if (pipe_vld_q[NST-1] && !m_tready) begin
					skid_vld_q <= 1'b1;
				end
			end else if (m_tready) begin
				skid_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && pipe_vld_q[NST-1] && !m_tready) begin
			skid_data_q <= res_data;
		end
	end

	assign m_tvalid = skid_vld_q || pipe_vld_q[NST-1];
	assign m_tdata  = skid_vld_q ? skid_data_q : res_data;

	// ------------------------------------------------------------------
	// Stage 1: mode handling, deadbands, scale clamp, heading negation.
	// ------------------------------------------------------------------
	logic                teleop_c;
	logic signed [16:0]  xs_c, ys_c, w_c;
	logic [15:0]         hneg_c;

	logic                tel_s1;
	logic signed [16:0]  x_s1, y_s1, w_s1;
	logic [15:0]         scale_s1, z_s1;

	always_comb begin
		teleop_c = !s_tuser;
		xs_c     = {s_tdata[15], s_tdata[15:0]};
		ys_c     = {s_tdata[31], s_tdata[31:16]};
		w_c      = {s_tdata[47], s_tdata[47:32]};
		if (teleop_c && s_tdata[80]) begin
			xs_c = -xs_c;
			ys_c = -ys_c;
		end
		ys_c = -ys_c;
		if (teleop_c) begin
			xs_c = swk_pkg::apply_deadband(xs_c, xdb_q);
			ys_c = swk_pkg::apply_deadband(ys_c, ydb_q);
			w_c  = swk_pkg::apply_deadband(w_c, tdb_q);
		end
		hneg_c = 16'h0000 - s_tdata[63:48];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tel_s1   <= teleop_c;
			x_s1     <= xs_c;
			y_s1     <= ys_c;
			w_s1     <= w_c;
			scale_s1 <= (s_tdata[79:64] > swk_pkg::SCALE_ONE) ? swk_pkg::SCALE_ONE
			                                                  : s_tdata[79:64];
			z_s1     <= hneg_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: quadrant fold for the rotation and the turn products.
	// ------------------------------------------------------------------
	logic                 fold_c;
	logic signed [RW-1:0] xw_c, yw_c;
	logic signed [33:0]   pl_c, pw_c;

	logic signed [RW-1:0] x_s2, y_s2;
	logic signed [31:0]   z_s2;
	swk_pkg::rot_side_t   side_s2;

	always_comb begin
		fold_c = (z_s1[15:14] == 2'b01) || (z_s1[15:14] == 2'b10);
		// The commands gain eight fraction bits and keep their sign.
		xw_c   = RW'($signed({x_s1, 8'h00}));
		yw_c   = RW'($signed({y_s1, 8'h00}));
		pl_c   = w_s1 * $signed({1'b0, kl_q});
		pw_c   = w_s1 * $signed({1'b0, kw_q});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2           <= fold_c ? -xw_c : xw_c;
			y_s2           <= fold_c ? -yw_c : yw_c;
			z_s2           <= $signed({z_s1[15] ^ fold_c, z_s1[14:0], 16'h0000});
			side_s2.teleop <= tel_s1;
			side_s2.scale  <= scale_s1;
			side_s2.turn_l <= RW'(pl_c >>> 7);
			side_s2.turn_w <= RW'(pw_c >>> 7);
		end
	end

	// ------------------------------------------------------------------
	// Stage group 3: rotation CORDIC, one micro-rotation per stage.
	// ------------------------------------------------------------------
	logic signed [RW-1:0] rx_s3 [N];
	logic signed [RW-1:0] ry_s3 [N];
	logic signed [31:0]   rz_s3 [N];
	swk_pkg::rot_side_t   rside_s3 [N];

	for (genvar i = 0; i < N; i++) begin : g_rot
		logic signed [RW-1:0] xi, yi;
		logic signed [31:0]   zi;
		swk_pkg::rot_side_t   si;
		if (i == 0) begin : g_first
			assign xi = x_s2;
			assign yi = y_s2;
			assign zi = z_s2;
			assign si = side_s2;
		end else begin : g_next
			assign xi = rx_s3[i-1];
			assign yi = ry_s3[i-1];
			assign zi = rz_s3[i-1];
			assign si = rside_s3[i-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (zi >= 0) begin
					rx_s3[i] <= xi - (yi >>> i);
					ry_s3[i] <= yi + (xi >>> i);
					rz_s3[i] <= zi - $signed(swk_pkg::ATAN_TAB[i]);
				end else begin
					rx_s3[i] <= xi + (yi >>> i);
					ry_s3[i] <= yi - (xi >>> i);
					rz_s3[i] <= zi + $signed(swk_pkg::ATAN_TAB[i]);
				end
				rside_s3[i] <= si;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: gain correction of the rotated command.
	// ------------------------------------------------------------------
	logic signed [RW+30:0] gx_c, gy_c;
	logic signed [RW-1:0]  x_s4, y_s4;
	swk_pkg::rot_side_t    side_s4;

	always_comb begin
		gx_c = rx_s3[N-1] * $signed({1'b0, swk_pkg::GAIN_Q30});
		gy_c = ry_s3[N-1] * $signed({1'b0, swk_pkg::GAIN_Q30});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s4    <= RW'(gx_c >>> 30);
			y_s4    <= RW'(gy_c >>> 30);
			side_s4 <= rside_s3[N-1];
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: wheel component sums a, b, c, d.
	// ------------------------------------------------------------------
	logic signed [RW-1:0] a_s5, b_s5, c_s5, d_s5;
	logic                 tel_s5;
	logic [15:0]          scale_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s5     <= x_s4 - side_s4.turn_l;
			b_s5     <= x_s4 + side_s4.turn_l;
			c_s5     <= y_s4 - side_s4.turn_w;
			d_s5     <= y_s4 + side_s4.turn_w;
			tel_s5   <= side_s4.teleop;
			scale_s5 <= side_s4.scale;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: per wheel half-plane fold for vectoring.
	// Lanes: front left (b, d), front right (b, c), rear left (a, d),
	// rear right (a, c); the first of each pair is the vector's y.
	// ------------------------------------------------------------------
	logic signed [VW-1:0] ly_c [4];
	logic signed [VW-1:0] lx_c [4];
	logic [3:0]           zero_c;

	logic signed [VW-1:0] x_s6 [4];
	logic signed [VW-1:0] y_s6 [4];
	logic [31:0]          z_s6 [4];
	swk_pkg::vec_side_t   side_s6;

	always_comb begin
		ly_c[0] = VW'(b_s5);
		lx_c[0] = VW'(d_s5);
		ly_c[1] = VW'(b_s5);
		lx_c[1] = VW'(c_s5);
		ly_c[2] = VW'(a_s5);
		lx_c[2] = VW'(d_s5);
		ly_c[3] = VW'(a_s5);
		lx_c[3] = VW'(c_s5);
		for (int l = 0; l < 4; l++) begin
			zero_c[l] = (lx_c[l] == 0) && (ly_c[l] == 0);
		end
	end

	for (genvar l = 0; l < 4; l++) begin : g_fold
		always_ff @(posedge clk) begin
			if (adv) begin
				if (lx_c[l] < 0) begin
					x_s6[l] <= -lx_c[l];
					y_s6[l] <= -ly_c[l];
					z_s6[l] <= 32'h8000_0000;
				end else begin
					x_s6[l] <= lx_c[l];
					y_s6[l] <= ly_c[l];
					z_s6[l] <= 32'h0000_0000;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s6.teleop <= tel_s5;
			side_s6.scale  <= scale_s5;
			side_s6.zero   <= zero_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage group 7: vectoring CORDIC, four lanes, one step per stage.
	// ------------------------------------------------------------------
	logic signed [VW-1:0] vx_s7 [N][4];
	logic signed [VW-1:0] vy_s7 [N][4];
	logic [31:0]          vz_s7 [N][4];
	swk_pkg::vec_side_t   vside_s7 [N];

	for (genvar i = 0; i < N; i++) begin : g_vec
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (adv) begin
					vside_s7[i] <= side_s6;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (adv) begin
					vside_s7[i] <= vside_s7[i-1];
				end
			end
		end
		for (genvar l = 0; l < 4; l++) begin : g_lane
			logic signed [VW-1:0] xi, yi;
			logic [31:0]          zi;
			if (i == 0) begin : g_first
				assign xi = x_s6[l];
				assign yi = y_s6[l];
				assign zi = z_s6[l];
			end else begin : g_next
				assign xi = vx_s7[i-1][l];
				assign yi = vy_s7[i-1][l];
				assign zi = vz_s7[i-1][l];
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					if (yi < 0) begin
						vx_s7[i][l] <= xi - (yi >>> i);
						vy_s7[i][l] <= yi + (xi >>> i);
						vz_s7[i][l] <= zi - swk_pkg::ATAN_TAB[i];
					end else begin
						vx_s7[i][l] <= xi + (yi >>> i);
						vy_s7[i][l] <= yi - (xi >>> i);
						vz_s7[i][l] <= zi + swk_pkg::ATAN_TAB[i];
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: gain corrected magnitude and rounded angle.
	// ------------------------------------------------------------------
	logic [MW-1:0] mag_s8 [4];
	logic [15:0]   ang_s8 [4];
	logic          tel_s8;
	logic [15:0]   scale_s8;

	for (genvar l = 0; l < 4; l++) begin : g_mag
		logic signed [VW+30:0] prod;
		logic signed [VW+30:0] m;
		logic [31:0]           zr;
		always_comb begin
			prod = vx_s7[N-1][l] * $signed({1'b0, swk_pkg::GAIN_Q30});
			m    = prod >>> 39;
			zr   = vz_s7[N-1][l] + 32'h0000_8000;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (vside_s7[N-1].zero[l] || m < 0) begin
					mag_s8[l] <= '0;
				end else begin
					mag_s8[l] <= MW'(m);
				end
				ang_s8[l] <= vside_s7[N-1].zero[l] ? 16'h0000 : zr[31:16];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tel_s8   <= vside_s7[N-1].teleop;
			scale_s8 <= vside_s7[N-1].scale;
		end
	end

	// ------------------------------------------------------------------
	// Stage 9: teleop speed scaling and saturation; result register.
	// ------------------------------------------------------------------
	logic [15:0] spd_s9 [4];
	logic [15:0] ang_s9 [4];

	for (genvar l = 0; l < 4; l++) begin : g_scale
		logic [MW+15:0] sp;
		logic [MW-1:0]  v;
		always_comb begin
			sp = mag_s8[l] * scale_s8;
			v  = tel_s8 ? MW'(sp >> 15) : mag_s8[l];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				spd_s9[l] <= (v > MW'(16'hFFFF)) ? 16'hFFFF : v[15:0];
				ang_s9[l] <= ang_s8[l];
			end
		end
	end

	assign res_data = {ang_s9[3], ang_s9[2], ang_s9[1], ang_s9[0],
	                   spd_s9[3], spd_s9[2], spd_s9[1], spd_s9[0]};

endmodule
